### src/bpc_pkg.sv
package bpc_pkg;

	// Datapath widths, all signed two's complement.
	localparam int DT_W   = 25;
	localparam int MUL_W  = 26;
	localparam int PROD_W = 2 * MUL_W;
	localparam int TEMP_W = 20;
	localparam int COEF_W = 36;
	localparam int ACC_W  = 60;
	localparam int DIFF_W = 41;
	localparam int PRES_W = 26;

	localparam logic [15:0] ABSENT_WORD = 16'hFFFF;

	localparam logic signed [TEMP_W-1:0] TEMP_BASE = 20'sd2000;
	// A compensated temperature in hundredths lands in -40..85 whole degrees
	// exactly when it lies in this window, since the division truncates.
	localparam logic signed [TEMP_W-1:0] TEMP_LO   = -20'sd4099;
	localparam logic signed [TEMP_W-1:0] TEMP_HI   = 20'sd8599;
	localparam logic signed [PRES_W-1:0] PRESS_LO  = 26'sd1000;
	localparam logic signed [PRES_W-1:0] PRESS_HI  = 26'sd120000;

	// Division by 100 as a multiplication by ceil(2^22/100), exact below 43690.
	localparam logic [15:0] DIV100_MUL = 16'd41944;
	localparam int DIV100_SHIFT = 22;

	// Configuration register indexes.
	localparam logic [2:0] CFG_FACTORY = 3'd0;
	localparam logic [2:0] CFG_C1      = 3'd1;
	localparam logic [2:0] CFG_C2      = 3'd2;
	localparam logic [2:0] CFG_C3      = 3'd3;
	localparam logic [2:0] CFG_C4      = 3'd4;
	localparam logic [2:0] CFG_C5      = 3'd5;
	localparam logic [2:0] CFG_C6      = 3'd6;

	// Sequencer steps, shared by the controller and the datapath.
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_TC6  = 4'd1;
	localparam logic [3:0] ST_DTSQ = 4'd2;
	localparam logic [3:0] ST_C4   = 4'd3;
	localparam logic [3:0] ST_C3   = 4'd4;
	localparam logic [3:0] ST_DEG  = 4'd5;
	localparam logic [3:0] ST_SLO  = 4'd6;
	localparam logic [3:0] ST_SHI  = 4'd7;
	localparam logic [3:0] ST_ACC  = 4'd8;
	localparam logic [3:0] ST_PDIV = 4'd9;
	localparam logic [3:0] ST_FIN  = 4'd10;

	typedef struct packed {
		logic [15:0] factory_word;
		logic [15:0] c1;
		logic [15:0] c2;
		logic [15:0] c3;
		logic [15:0] c4;
		logic [15:0] c5;
		logic [15:0] c6;
	} cal_t;

	typedef struct packed {
		logic       load;
		logic       finish;
		logic [3:0] step;
	} dp_cmd_t;

endpackage

### src/bpc_cfg.sv
module bpc_cfg import bpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output cal_t        cal
);

	cal_t cal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q.factory_word <= ABSENT_WORD;
			cal_q.c1           <= '0;
			cal_q.c2           <= '0;
			cal_q.c3           <= '0;
			cal_q.c4           <= '0;
			cal_q.c5           <= '0;
			cal_q.c6           <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FACTORY: cal_q.factory_word <= cfg_data;
				CFG_C1:      cal_q.c1 <= cfg_data;
				CFG_C2:      cal_q.c2 <= cfg_data;
				CFG_C3:      cal_q.c3 <= cfg_data;
				CFG_C4:      cal_q.c4 <= cfg_data;
				CFG_C5:      cal_q.c5 <= cfg_data;
				CFG_C6:      cal_q.c6 <= cfg_data;
				default:     cal_q <= cal_q;
			endcase
		end
	end

	assign cal = cal_q;

endmodule

### src/bpc_ctrl.sv
module bpc_ctrl import bpc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_valid,
	output logic    s_ready,
	output logic    m_valid,
	input  logic    m_ready,
	output dp_cmd_t cmd
);

	logic [3:0] state_q;
	logic [3:0] state_n;
	logic       out_valid_q;
	logic       accept;
	logic       finish;

	assign s_ready = (state_q == ST_IDLE);
	assign accept  = s_valid && s_ready;
	// The result register may be refilled in the cycle its word is taken.
	assign finish  = (state_q == ST_FIN) && (!out_valid_q || m_ready);

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: if (accept) state_n = ST_TC6;
			ST_TC6:  state_n = ST_DTSQ;
			ST_DTSQ: state_n = ST_C4;
			ST_C4:   state_n = ST_C3;
			ST_C3:   state_n = ST_DEG;
			ST_DEG:  state_n = ST_SLO;
			ST_SLO:  state_n = ST_SHI;
			ST_SHI:  state_n = ST_ACC;
			ST_ACC:  state_n = ST_PDIV;
			ST_PDIV: state_n = ST_FIN;
			ST_FIN:  if (finish) state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_valid    = out_valid_q;
	assign cmd.load   = accept;
	assign cmd.finish = finish;
	assign cmd.step   = state_q;

endmodule

### src/bpc_dp.sv
module bpc_dp import bpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	input  cal_t        cal,
	input  logic [23:0] pressure_raw,
	input  logic [23:0] temperature_raw,
	output logic [7:0]  temperature_c,
	output logic [16:0] pressure_pa,
	output logic        temperature_updated,
	output logic        pressure_updated,
	output logic        sensor_absent
);

	localparam logic signed [PROD_W-1:0] BIAS23 = 52'sd8388607;
	localparam logic signed [PROD_W-1:0] BIAS8  = 52'sd255;
	localparam logic signed [PROD_W-1:0] BIAS7  = 52'sd127;
	localparam logic signed [ACC_W-1:0]  BIAS21 = 60'sd2097151;
	localparam logic signed [DIFF_W-1:0] BIAS15 = 41'sd32767;

	logic [23:0]               d1_q;
	logic signed [DT_W-1:0]    dt_q;
	logic signed [TEMP_W-1:0]  t1_q;
	logic signed [TEMP_W-1:0]  temp_q;
	logic signed [COEF_W-1:0]  off_q;
	logic signed [COEF_W-1:0]  sens_q;
	logic [7:0]                deg_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [DIFF_W-1:0]  pdiff_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic [7:0]                held_temp_q;
	logic [16:0]               held_press_q;
	logic                      t_upd_q;
	logic                      p_upd_q;
	logic                      absent_q;

	logic signed [MUL_W-1:0]   mul_a;
	logic signed [MUL_W-1:0]   mul_b;
	logic signed [DT_W-1:0]    dt_n;
	logic signed [TEMP_W-1:0]  temp_neg;
	logic [13:0]               temp_mag;
	logic signed [PROD_W-1:0]  q23;
	logic signed [PROD_W-1:0]  q31;
	logic signed [PROD_W-1:0]  q7;
	logic signed [PROD_W-1:0]  q8;
	logic [7:0]                deg_mag;
	logic [7:0]                deg_n;
	logic signed [ACC_W-1:0]   prod_ext;
	logic signed [ACC_W-1:0]   q21;
	logic signed [DIFF_W-1:0]  q15;
	logic signed [PRES_W-1:0]  press_n;
	logic                      t_in;
	logic                      p_in;
	logic                      absent;

	assign dt_n = $signed({1'b0, temperature_raw}) - $signed({1'b0, cal.c5, 8'd0});

	assign temp_neg = -temp_q;
	assign temp_mag = temp_q[TEMP_W-1] ? temp_neg[13:0] : temp_q[13:0];

	// One shared signed multiplier; each step picks its operand pair.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.step)
			ST_TC6: begin
				mul_a = {dt_q[DT_W-1], dt_q};
				mul_b = {10'd0, cal.c6};
			end
			ST_DTSQ: begin
				mul_a = {dt_q[DT_W-1], dt_q};
				mul_b = {dt_q[DT_W-1], dt_q};
			end
			ST_C4: begin
				mul_a = {dt_q[DT_W-1], dt_q};
				mul_b = {10'd0, cal.c4};
			end
			ST_C3: begin
				mul_a = {dt_q[DT_W-1], dt_q};
				mul_b = {10'd0, cal.c3};
			end
			ST_DEG: begin
				mul_a = {12'd0, temp_mag};
				mul_b = {10'd0, DIV100_MUL};
			end
			ST_SLO: begin
				mul_a = {2'd0, d1_q};
				mul_b = {9'd0, sens_q[16:0]};
			end
			ST_SHI: begin
				mul_a = {2'd0, d1_q};
				mul_b = {{7{sens_q[COEF_W-1]}}, sens_q[COEF_W-1:17]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Signed divisions by powers of two round toward zero: bias negatives first.
	assign q23 = (prod_q + (prod_q[PROD_W-1] ? BIAS23 : 52'sd0)) >>> 23;
	assign q31 = prod_q >>> 31;
	assign q7  = (prod_q + (prod_q[PROD_W-1] ? BIAS7 : 52'sd0)) >>> 7;
	assign q8  = (prod_q + (prod_q[PROD_W-1] ? BIAS8 : 52'sd0)) >>> 8;
	assign deg_mag  = prod_q[DIV100_SHIFT+7:DIV100_SHIFT];
	assign deg_n    = temp_q[TEMP_W-1] ? (8'd0 - deg_mag) : deg_mag;
	assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
	assign q21 = (acc_q + (acc_q[ACC_W-1] ? BIAS21 : 60'sd0)) >>> 21;
	assign q15 = (pdiff_q + (pdiff_q[DIFF_W-1] ? BIAS15 : 41'sd0)) >>> 15;
	assign press_n = q15[PRES_W-1:0];

	assign absent = (cal.factory_word == ABSENT_WORD);
	assign t_in   = (temp_q >= TEMP_LO) && (temp_q <= TEMP_HI);
	assign p_in   = (press_n >= PRESS_LO) && (press_n <= PRESS_HI);

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (cmd.load) begin
			d1_q <= pressure_raw;
			dt_q <= dt_n;
		end
		case (cmd.step)
			ST_DTSQ: t1_q <= TEMP_BASE + $signed(q23[TEMP_W-1:0]);
			ST_C4: begin
				if (t1_q < TEMP_BASE) begin
					temp_q <= t1_q - $signed(q31[TEMP_W-1:0]);
				end else begin
					temp_q <= t1_q;
				end
			end
			ST_C3:   off_q <= $signed({4'd0, cal.c2, 16'd0}) + $signed(q7[COEF_W-1:0]);
			ST_DEG:  sens_q <= $signed({5'd0, cal.c1, 15'd0}) + $signed(q8[COEF_W-1:0]);
			ST_SLO:  deg_q <= deg_n;
			ST_SHI:  acc_q <= prod_ext;
			ST_ACC:  acc_q <= acc_q + (prod_ext <<< 17);
			ST_PDIV: pdiff_q <= $signed(q21[DIFF_W-1:0])
				- $signed({{(DIFF_W-COEF_W){off_q[COEF_W-1]}}, off_q});
			default: acc_q <= acc_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_temp_q  <= '0;
			held_press_q <= '0;
			t_upd_q      <= 1'b0;
			p_upd_q      <= 1'b0;
			absent_q     <= 1'b0;
		end else if (cmd.finish) begin
			absent_q <= absent;
			if (absent) begin
				held_temp_q  <= '0;
				held_press_q <= '0;
				t_upd_q      <= 1'b0;
				p_upd_q      <= 1'b0;
			end else begin
				t_upd_q <= t_in;
				p_upd_q <= p_in;
				if (t_in) begin
					held_temp_q <= deg_q;
				end
				if (p_in) begin
					held_press_q <= press_n[16:0];
				end
			end
		end
	end

	assign temperature_c       = held_temp_q;
	assign pressure_pa         = held_press_q;
	assign temperature_updated = t_upd_q;
	assign pressure_updated    = p_upd_q;
	assign sensor_absent       = absent_q;

endmodule

### src/barometric_pressure_compensation_core.sv
// One word is processed at a time: one 26x26 multiplier serves seven operand pairs,
// then two add stages and a result stage, and the idle step takes the next word.
// A new input word is taken while the previous result still waits downstream.
// Reset is asynchronous, active low: held values and flags clear to zero and
// the factory word resets to all ones, so the sensor reads as absent.
module barometric_pressure_compensation_core import bpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [23:0] pressure_raw, [47:24] temperature_raw
	input  logic [47:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] temperature_c, [24:8] pressure_pa, [31:25] zero
	output logic [31:0] m_axis_tdata,
	// [0] temperature_updated, [1] pressure_updated, [2] sensor_absent
	output logic [2:0]  m_axis_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cal_t        cal;
	dp_cmd_t     cmd;
	logic [7:0]  temperature_c;
	logic [16:0] pressure_pa;
	logic        temperature_updated;
	logic        pressure_updated;
	logic        sensor_absent;

	assign cfg_ready = 1'b1;

	bpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cal       (cal)
	);

	bpc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.cmd     (cmd)
	);

	bpc_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.cal                 (cal),
		.pressure_raw        (s_axis_tdata[23:0]),
		.temperature_raw     (s_axis_tdata[47:24]),
		.temperature_c       (temperature_c),
		.pressure_pa         (pressure_pa),
		.temperature_updated (temperature_updated),
		.pressure_updated    (pressure_updated),
		.sensor_absent       (sensor_absent)
	);

	assign m_axis_tdata = {7'd0, pressure_pa, temperature_c};
	assign m_axis_tuser = {sensor_absent, pressure_updated, temperature_updated};

endmodule

### tb/barometric_pressure_compensation_core_tb.sv
`timescale 1ns / 100ps

module barometric_pressure_compensation_core_tb;
	import bpc_pkg::*;

	localparam logic [2:0] CFG_UNUSED = 3'd7;

	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_BLOCKS = 8;
	localparam int ITEMS_PER_BLOCK = 75;
	localparam int DRAIN_CYCLES = 24;
	localparam int MAX_PRINTED = 40;

	// Fixed-point scale factors of the compensation formulas.
	localparam longint C5_SCALE    = 64'sd256;
	localparam longint TEMP_DIV    = 64'sh80_0000;
	localparam longint TEMP_SQ_DIV = 64'sh8000_0000;
	localparam longint OFF_SCALE   = 64'sd65536;
	localparam longint OFF_TC_DIV  = 64'sd128;
	localparam longint SENS_SCALE  = 64'sd32768;
	localparam longint SENS_TC_DIV = 64'sd256;
	localparam longint P_SENS_DIV  = 64'sh20_0000;
	localparam longint P_DIV       = 64'sd32768;
	localparam longint TEMP_REF    = 64'sd2000;
	localparam longint CENTI       = 64'sd100;
	localparam longint DEG_MIN     = -64'sd40;
	localparam longint DEG_MAX     = 64'sd85;
	localparam longint PA_MIN      = 64'sd1000;
	localparam longint PA_MAX      = 64'sd120000;

	// Calibration set of a typical part; in most random blocks C1 to C4 and C6 jitter around it.
	localparam int TYP_C1 = 40127;
	localparam int TYP_C2 = 36924;
	localparam int TYP_C3 = 23317;
	localparam int TYP_C4 = 23282;
	localparam int TYP_C5 = 33464;
	localparam int TYP_C6 = 28312;
	localparam logic [23:0] TYP_D1 = 24'd9085466;
	localparam logic [23:0] TYP_D2 = 24'd8569150;

	typedef struct packed {
		logic [7:0]  temp_c;
		logic [16:0] press_pa;
		logic        t_upd;
		logic        p_upd;
		logic        absent;
	} reading_t;

	typedef struct packed {
		logic        is_cfg;
		logic [2:0]  index;
		logic [15:0] value;
		logic [23:0] press_raw;
		logic [23:0] temp_raw;
		logic        typed;
		reading_t    want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	logic [15:0] cal_words [7];
	logic [7:0]  held_temp = '0;
	logic [16:0] held_press = '0;

	reading_t  pending_readings [$];
	stim_row_t stim_table [$];

	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int error_count = 0;
	int words_seen = 0;
	int cycle_count = 0;

	barometric_pressure_compensation_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Compensates one raw pair with the current calibration and updates the held values.
	function automatic reading_t compensate(input logic [23:0] press_raw,
			input logic [23:0] temp_raw);
		reading_t r;
		longint c1, c2, c3, c4, c5, c6;
		longint dt, temp, deg, off, sens, pa;
		r = '0;
		r.absent = (cal_words[CFG_FACTORY] == ABSENT_WORD);
		if (r.absent) begin
			held_temp = '0;
			held_press = '0;
		end else begin
			c1 = cal_words[CFG_C1];
			c2 = cal_words[CFG_C2];
			c3 = cal_words[CFG_C3];
			c4 = cal_words[CFG_C4];
			c5 = cal_words[CFG_C5];
			c6 = cal_words[CFG_C6];
			dt = longint'(temp_raw) - c5 * C5_SCALE;
			temp = TEMP_REF + (dt * c6) / TEMP_DIV;
			// Second-order correction below twenty degrees.
			if (temp < TEMP_REF) begin
				temp = temp - (dt * dt) / TEMP_SQ_DIV;
			end
			deg = temp / CENTI;
			if (deg >= DEG_MIN && deg <= DEG_MAX) begin
				held_temp = deg[7:0];
				r.t_upd = 1'b1;
			end
			off = c2 * OFF_SCALE + (c4 * dt) / OFF_TC_DIV;
			sens = c1 * SENS_SCALE + (c3 * dt) / SENS_TC_DIV;
			pa = ((longint'(press_raw) * sens) / P_SENS_DIV - off) / P_DIV;
			if (pa >= PA_MIN && pa <= PA_MAX) begin
				held_press = pa[16:0];
				r.p_upd = 1'b1;
			end
		end
		r.temp_c = held_temp;
		r.press_pa = held_press;
		return r;
	endfunction

	function automatic stim_row_t cfg_row(input logic [2:0] index, input logic [15:0] value);
		stim_row_t row;
		row = '0;
		row.is_cfg = 1'b1;
		row.index = index;
		row.value = value;
		return row;
	endfunction

	function automatic stim_row_t item_row(input logic [23:0] press_raw,
			input logic [23:0] temp_raw);
		stim_row_t row;
		row = '0;
		row.press_raw = press_raw;
		row.temp_raw = temp_raw;
		return row;
	endfunction

	function automatic stim_row_t typed_row(input logic [23:0] press_raw,
			input logic [23:0] temp_raw, input logic [7:0] temp_c,
			input logic [16:0] press_pa, input logic [2:0] flags);
		stim_row_t row;
		row = item_row(press_raw, temp_raw);
		row.typed = 1'b1;
		row.want.temp_c = temp_c;
		row.want.press_pa = press_pa;
		row.want.t_upd = flags[0];
		row.want.p_upd = flags[1];
		row.want.absent = flags[2];
		return row;
	endfunction

	task automatic report_mismatch(input string field, input longint got, input longint want);
		if (error_count < MAX_PRINTED) begin
			$display("mismatch at word %0d, %s: got %0d, expected %0d",
				words_seen, field, got, want);
		end
		error_count++;
	endtask

	task automatic wait_for_readings();
		s_axis_tvalid <= 1'b0;
		cfg_valid <= 1'b0;
		while (pending_readings.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic send_reading(input logic [23:0] press_raw, input logic [23:0] temp_raw,
			input logic typed, input reading_t want);
		reading_t predicted;
		cfg_valid <= 1'b0;
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {temp_raw, press_raw};
		do @(posedge clk); while (!s_axis_tready);
		predicted = compensate(press_raw, temp_raw);
		pending_readings.push_back(typed ? want : predicted);
	endtask

	task automatic set_register(input logic [2:0] index, input logic [15:0] value);
		wait_for_readings();
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		if (index <= CFG_C6) begin
			cal_words[index] = value;
		end
	endtask

	function automatic logic [15:0] jitter(input int base);
		return 16'(base + int'($urandom_range(0, 8191)) - 4096);
	endfunction

	always @(posedge clk) begin : receive_side
		reading_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_readings.size() == 0) begin
				report_mismatch("word with no reading pending", m_axis_tdata, 0);
			end else begin
				want = pending_readings.pop_front();
				if (m_axis_tdata[7:0] !== want.temp_c)
					report_mismatch("temperature_c", m_axis_tdata[7:0], want.temp_c);
				if (m_axis_tdata[24:8] !== want.press_pa)
					report_mismatch("pressure_pa", m_axis_tdata[24:8], want.press_pa);
				if (m_axis_tdata[31:25] !== 7'd0)
					report_mismatch("tdata padding", m_axis_tdata[31:25], 0);
				if (m_axis_tuser[0] !== want.t_upd)
					report_mismatch("temperature_updated", m_axis_tuser[0], want.t_upd);
				if (m_axis_tuser[1] !== want.p_upd)
					report_mismatch("pressure_updated", m_axis_tuser[1], want.p_upd);
				if (m_axis_tuser[2] !== want.absent)
					report_mismatch("sensor_absent", m_axis_tuser[2], want.absent);
			end
			words_seen <= words_seen + 1;
		end
		m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
	end

	initial begin : stimulus
		stim_row_t row;
		logic [23:0] d1, d2;
		longint t;
		int i, b, n, drain_at, kind;
		for (i = 0; i < 7; i++) begin
			cal_words[i] = '0;
		end
		cal_words[CFG_FACTORY] = ABSENT_WORD;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Out of reset the sensor reads as absent and everything is zero.
		stim_table.push_back(typed_row(24'd0, 24'd0, 8'd0, 17'd0, 3'b100));
		stim_table.push_back(typed_row(24'hFFFFFF, 24'hFFFFFF, 8'd0, 17'd0, 3'b100));
		// Present, all coefficients zero: twenty degrees, pressure zero and rejected.
		stim_table.push_back(cfg_row(CFG_FACTORY, 16'h0000));
		stim_table.push_back(typed_row(24'd0, 24'd0, 8'd20, 17'd0, 3'b001));
		stim_table.push_back(typed_row(24'hFFFFFF, 24'hFFFFFF, 8'd20, 17'd0, 3'b001));
		// A write to the unused index must not touch the factory word.
		stim_table.push_back(cfg_row(CFG_UNUSED, 16'hFFFF));
		stim_table.push_back(typed_row(24'd0, 24'd0, 8'd20, 17'd0, 3'b001));
		stim_table.push_back(cfg_row(CFG_C1, 16'(TYP_C1)));
		stim_table.push_back(cfg_row(CFG_C2, 16'(TYP_C2)));
		stim_table.push_back(cfg_row(CFG_C3, 16'(TYP_C3)));
		stim_table.push_back(cfg_row(CFG_C4, 16'(TYP_C4)));
		stim_table.push_back(cfg_row(CFG_C5, 16'(TYP_C5)));
		stim_table.push_back(cfg_row(CFG_C6, 16'(TYP_C6)));
		stim_table.push_back(item_row(TYP_D1, TYP_D2));
		// Too cold and too hot, then pressure too low and too high; held values stay.
		stim_table.push_back(item_row(TYP_D1, 24'd6000000));
		stim_table.push_back(item_row(TYP_D1, 24'd11000000));
		stim_table.push_back(item_row(24'd0, TYP_D2));
		stim_table.push_back(item_row(24'hFFFFFF, TYP_D2));
		stim_table.push_back(item_row(24'd0, 24'd0));
		stim_table.push_back(item_row(24'hFFFFFF, 24'hFFFFFF));
		// Cold but in range, so the second-order term applies.
		stim_table.push_back(item_row(TYP_D1, 24'd7566784));
		stim_table.push_back(cfg_row(CFG_FACTORY, 16'hFFFE));
		for (i = 1; i <= 6; i++) begin
			stim_table.push_back(cfg_row(3'(i), 16'hFFFF));
		end
		stim_table.push_back(item_row(24'd0, 24'd0));
		stim_table.push_back(item_row(24'hFFFFFF, 24'hFFFFFF));
		stim_table.push_back(item_row(24'h800000, 24'hFFFF00));
		// Sensor absent again: held values clear.
		stim_table.push_back(cfg_row(CFG_FACTORY, ABSENT_WORD));
		stim_table.push_back(typed_row(TYP_D1, TYP_D2, 8'd0, 17'd0, 3'b100));

		for (i = 0; i < stim_table.size(); i++) begin
			row = stim_table[i];
			if (row.is_cfg) begin
				set_register(row.index, row.value);
			end else begin
				send_reading(row.press_raw, row.temp_raw, row.typed, row.want);
			end
		end

		for (b = 0; b < RANDOM_BLOCKS; b++) begin
			case (b % 4)
				0: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 54;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 54;
				end
				default: begin
					sender_idle_pct = 21;
					receiver_stall_pct = 21;
				end
			endcase
			if (b == 2) begin
				set_register(CFG_FACTORY, 16'($urandom_range(0, 65534)));
				for (i = 1; i <= 6; i++) begin
					set_register(3'(i), 16'($urandom_range(0, 65535)));
				end
			end else begin
				if (b == 5) begin
					set_register(CFG_FACTORY, ABSENT_WORD);
				end else begin
					set_register(CFG_FACTORY, 16'($urandom_range(0, 65534)));
				end
				set_register(CFG_C1, jitter(TYP_C1));
				set_register(CFG_C2, jitter(TYP_C2));
				set_register(CFG_C3, jitter(TYP_C3));
				set_register(CFG_C4, jitter(TYP_C4));
				set_register(CFG_C5, 16'($urandom_range(0, 65535)));
				set_register(CFG_C6, jitter(TYP_C6));
			end
			drain_at = $urandom_range(10, ITEMS_PER_BLOCK - 10);
			for (n = 0; n < ITEMS_PER_BLOCK; n++) begin
				if (n == drain_at) begin
					wait_for_readings();
				end
				kind = $urandom_range(0, 99);
				if (kind < 70) begin
					// Plausible conversion: temperature near the reference point.
					t = longint'(cal_words[CFG_C5]) * C5_SCALE
						+ longint'(int'($urandom_range(0, 4194304)) - 2097152);
					if (t < 0) begin
						t = 0;
					end else if (t > 64'sh00FF_FFFF) begin
						t = 64'sh00FF_FFFF;
					end
					d2 = t[23:0];
					d1 = 24'($urandom_range(5000000, 12000000));
				end else begin
					d1 = 24'($urandom());
					d2 = 24'($urandom());
				end
				send_reading(d1, d2, 1'b0, '0);
			end
		end

		wait_for_readings();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
